### src/sld_pkg.sv
// Shared types, constants and functions of the sync/length/XOR deframer.
// Used by sld_apb_regs, sld_parser and sync_length_xor_deframer.
package sld_pkg;

  localparam logic [7:0]  SyncReset      = 8'hA5;
  localparam logic [8:0]  MaxLenReset    = 9'd256;
  localparam logic [15:0] MaxFrame       = 16'd256;
  localparam logic [15:0] HeaderTrailer  = 16'd5;
  localparam logic [15:0] BodyLimitTotal = 16'd260;

  localparam logic [7:0] CmdHandshake = 8'h02;
  localparam logic [7:0] CmdWrite     = 8'h27;
  localparam logic [7:0] CmdSend      = 8'h28;
  localparam logic [7:0] CmdRead      = 8'h29;
  localparam logic [7:0] CmdReceive   = 8'h2A;

  localparam int unsigned TdataOutW = 40;

  typedef enum logic [0:0] {
    RegSyncValue = 1'b0,
    RegMaxLen    = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusBadSync  = 2'd1,
    StatusBadLen   = 2'd2,
    StatusBadCheck = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ClassHandshake = 3'd0,
    ClassWrite     = 3'd1,
    ClassSend      = 3'd2,
    ClassRead      = 3'd3,
    ClassReceive   = 3'd4,
    ClassUnknown   = 3'd5
  } class_e;

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhCmd   = 3'd1,
    PhLenHi = 3'd2,
    PhLenLo = 3'd3,
    PhBody  = 3'd4,
    PhCheck = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [8:0] max_frame_length;
  } cfg_t;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic [7:0] body_index;
    logic       frame_done;
    status_e    frame_status;
    logic [7:0] command;
    class_e     command_class;
    logic [7:0] body_length;
  } result_t;

  function automatic class_e class_of(logic [7:0] cmd);
    class_e cls;
    case (cmd)
      CmdHandshake: cls = ClassHandshake;
      CmdWrite:     cls = ClassWrite;
      CmdSend:      cls = ClassSend;
      CmdRead:      cls = ClassRead;
      CmdReceive:   cls = ClassReceive;
      default:      cls = ClassUnknown;
    endcase
    return cls;
  endfunction

endpackage

### src/sync_length_xor_deframer.sv
// Top level of the sync/length/XOR deframer: input register, parser, result register.
// Depends on sld_pkg, sld_apb_regs and sld_parser.
//
// The slave stream carries one received byte per beat. The master stream returns one
// result beat for every input beat: tuser flags a body byte, tlast marks the beat that
// ends a frame or reports an error, and tdata carries the byte, its body index, the
// status, the command, its class and the body length.
// A byte is registered in the input register on acceptance and its result is registered
// in the result register when the byte advances, which waits while a held result is not
// taken. One byte per cycle is sustained as long as the master side takes results; the
// parser state updates once per byte.
// When the master stalls, the result register holds and one further byte waits in the
// input register; tready falls only when both are full and the master is not ready.
// Reset clears the frame state to waiting for sync, empties both registers and sets the
// sync value to 0xA5 and the maximum frame length to 256. The APB port writes the two
// registers at byte addresses 0 and 4; writes are meant for idle periods only.
module sync_length_xor_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [sld_pkg::TdataOutW-1:0] m_axis_tdata, // [7:0] body_byte, [15:8] body_index,
                                      // [17:16] frame_status, [25:18] command,
                                      // [28:26] command_class, [36:29] body_length
  output logic        m_axis_tuser,   // [0] body_valid
  output logic        m_axis_tlast    // frame_done
);

  sld_pkg::cfg_t    cfg;
  sld_pkg::result_t result;
  sld_pkg::result_t out_q;
  logic             in_valid_q, in_valid_d;
  logic [7:0]       in_byte_q;
  logic             out_valid_q, out_valid_d;
  logic             advance;
  logic             in_take;

  sld_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sld_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;
  assign in_valid_d    = in_take | (in_valid_q & ~advance);
  assign out_valid_d   = advance | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.body_valid;
  assign m_axis_tlast  = out_q.frame_done;
  assign m_axis_tdata  = {3'd0, out_q.body_length, out_q.command_class, out_q.command,
                          out_q.frame_status, out_q.body_index, out_q.body_byte};

endmodule

### src/sld_apb_regs.sv
// APB configuration registers of the deframer: sync value and maximum frame length.
// Depends on sld_pkg.
module sld_apb_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output sld_pkg::cfg_t    cfg_o
);

  logic [7:0]        sync_value_q;
  logic [8:0]        max_len_q;
  logic              wr_en;
  sld_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = sld_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_value_q <= sld_pkg::SyncReset;
      max_len_q    <= sld_pkg::MaxLenReset;
    end else if (wr_en) begin
      if (idx == sld_pkg::RegSyncValue) begin
        sync_value_q <= pwdata[7:0];
      end else begin
        max_len_q <= pwdata[8:0];
      end
    end
  end

  always_comb begin
    case (idx)
      sld_pkg::RegSyncValue: prdata = {24'd0, sync_value_q};
      sld_pkg::RegMaxLen:    prdata = {23'd0, max_len_q};
      default:               prdata = 32'd0;
    endcase
  end

  assign cfg_o.sync_value       = sync_value_q;
  assign cfg_o.max_frame_length = max_len_q;

endmodule

### src/sld_parser.sv
// Frame parser state and the per-byte result logic of the deframer.
// Depends on sld_pkg.
module sld_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  sld_pkg::cfg_t     cfg_i,
  output sld_pkg::result_t  result_o
);

  sld_pkg::phase_e phase_q, phase_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [8:0]  remain_q, remain_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] total;
  logic        len_bad;
  logic [8:0]  remain_dec;

  assign total      = {len_hi_q, byte_i};
  assign len_bad    = (total < sld_pkg::HeaderTrailer)
                    || (total > {7'd0, cfg_i.max_frame_length})
                    || (total > sld_pkg::MaxFrame)
                    || (total > sld_pkg::BodyLimitTotal);
  assign remain_dec = (remain_q != 9'd0) ? remain_q - 9'd1 : remain_q;

  always_comb begin
    case (phase_q)
      sld_pkg::PhCmd:   phase_d = sld_pkg::PhLenHi;
      sld_pkg::PhLenHi: phase_d = sld_pkg::PhLenLo;
      sld_pkg::PhLenLo: begin
        if (len_bad) begin
          phase_d = sld_pkg::PhIdle;
        end else if (total == sld_pkg::HeaderTrailer) begin
          phase_d = sld_pkg::PhCheck;
        end else begin
          phase_d = sld_pkg::PhBody;
        end
      end
      sld_pkg::PhBody:  phase_d = (remain_dec == 9'd0) ? sld_pkg::PhCheck : sld_pkg::PhBody;
      sld_pkg::PhCheck: phase_d = sld_pkg::PhIdle;
      default:          phase_d = (byte_i == cfg_i.sync_value) ? sld_pkg::PhCmd
                                                               : sld_pkg::PhIdle;
    endcase
  end

  always_comb begin
    xor_d    = xor_q;
    cmd_d    = cmd_q;
    len_hi_d = len_hi_q;
    remain_d = remain_q;
    count_d  = count_q;
    result_o = '0;
    result_o.frame_status  = sld_pkg::StatusOk;
    result_o.command_class = sld_pkg::ClassHandshake;
    case (phase_q)
      sld_pkg::PhCmd: begin
        cmd_d = byte_i;
        xor_d = xor_q ^ byte_i;
      end
      sld_pkg::PhLenHi: begin
        len_hi_d = byte_i;
        xor_d    = xor_q ^ byte_i;
      end
      sld_pkg::PhLenLo: begin
        xor_d = xor_q ^ byte_i;
        if (len_bad) begin
          result_o.frame_done    = 1'b1;
          result_o.frame_status  = sld_pkg::StatusBadLen;
          result_o.command       = cmd_q;
          result_o.command_class = sld_pkg::class_of(cmd_q);
        end else begin
          remain_d = 9'(total - sld_pkg::HeaderTrailer);
          count_d  = 8'd0;
        end
      end
      sld_pkg::PhBody: begin
        result_o.body_valid = 1'b1;
        result_o.body_byte  = byte_i;
        result_o.body_index = count_q;
        xor_d    = xor_q ^ byte_i;
        count_d  = count_q + 8'd1;
        remain_d = remain_dec;
      end
      sld_pkg::PhCheck: begin
        result_o.frame_done    = 1'b1;
        result_o.frame_status  = (byte_i == xor_q) ? sld_pkg::StatusOk
                                                   : sld_pkg::StatusBadCheck;
        result_o.command       = cmd_q;
        result_o.command_class = sld_pkg::class_of(cmd_q);
        result_o.body_length   = count_q;
      end
      default: begin
        if (byte_i == cfg_i.sync_value) begin
          xor_d    = byte_i;
          cmd_d    = 8'd0;
          len_hi_d = 8'd0;
          remain_d = 9'd0;
          count_d  = 8'd0;
        end else begin
          result_o.frame_done    = 1'b1;
          result_o.frame_status  = sld_pkg::StatusBadSync;
          result_o.command_class = sld_pkg::ClassUnknown;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sld_pkg::PhIdle;
      xor_q    <= 8'd0;
      cmd_q    <= 8'd0;
      len_hi_q <= 8'd0;
      remain_q <= 9'd0;
      count_q  <= 8'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      xor_q    <= xor_d;
      cmd_q    <= cmd_d;
      len_hi_q <= len_hi_d;
      remain_q <= remain_d;
      count_q  <= count_d;
    end
  end

endmodule
